// ===== sv/rpn_pkg.sv =====
// rpn calculator shared types, codes and field widths
`default_nettype none

package rpn_pkg;

  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 7;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // token kinds; codes above divide behave as multiply
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4
  } cmd_t;

  // per-token status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 3'd0,
    ST_FEW  = 3'd1,
    ST_DIVZ = 3'd2,
    ST_FULL = 3'd3,
    ST_HALT = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== sv/rpn_in_if.sv =====
// token channel: valid/ready handshake with command and value payload
`default_nettype none

interface rpn_in_if;
  logic                              valid;
  logic                              ready;
  logic [rpn_pkg::CMD_W-1:0]         cmd;
  logic signed [rpn_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_out_if.sv =====
// result channel: valid/ready handshake with status, top, depth and answer flag
`default_nettype none

interface rpn_out_if;
  logic                                valid;
  logic                                ready;
  logic [rpn_pkg::STATUS_W-1:0]        status;
  logic signed [rpn_pkg::DATA_W-1:0]   top_value;
  logic [rpn_pkg::DEPTH_W-1:0]         depth;
  logic                                answer_ready;

  modport source (output valid, output status, output top_value, output depth,
                  output answer_ready, input ready);
  modport sink   (input valid, input status, input top_value, input depth,
                  input answer_ready, output ready);
endinterface

`default_nettype wire

// ===== sv/rpn_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rpn_stack_calculator_unit.sv =====
// rpn stack calculator: operand stack in ram, cached top, serial divider
// push writes and finishes; add/sub/mul read the entry under the top, write back;
// divide by zero reads, reloads the new top if entries remain; divide reads, runs
// 32 restoring steps, writes back; in ready only while the sequencer is idle,
// and a finished result waits in the output register until taken
// reset (synchronous, active low) clears depth, halt flag, sequencer and out valid;
// stack ram is not cleared, an entry is only read after it was written
`default_nettype none

module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  rpn_in_if.sink      in_ch,
  rpn_out_if.source   out_ch
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DW  = rpn_pkg::DATA_W;
  localparam int CW  = rpn_pkg::DIV_CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIVIDE,
    S_DIV_DONE,
    S_RELOAD,
    S_FINISH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [SPW-1:0]              sp_r, sp_nxt;
  logic                        halted_r, halted_nxt;
  logic [DW-1:0]               top_r, top_nxt;
  logic [rpn_pkg::CMD_W-1:0]   cmd_r, cmd_nxt;
  rpn_pkg::status_t            status_r, status_nxt;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [DW-1:0]               quo_r, quo_nxt;
  logic [DW-1:0]               den_r, den_nxt;
  logic                        neg_r, neg_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;

  logic                        out_valid_r, out_valid_nxt;
  rpn_pkg::status_t            out_status_r, out_status_nxt;
  logic [DW-1:0]               out_top_r, out_top_nxt;
  logic [rpn_pkg::DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic                        out_answer_r, out_answer_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [DW-1:0]               ram_wdata, ram_rdata;

  logic                        in_accept;
  logic [SPW-1:0]              sp_m1, sp_m2, sp_m3;
  logic [DW-1:0]               earlier, later, prod, quot;
  logic [DW:0]                 trial;
  logic [SPW+rpn_pkg::DEPTH_W-1:0] sp_ext;

  rpn_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.top_value   = $signed(out_top_r);
  assign out_ch.depth       = out_depth_r;
  assign out_ch.answer_ready = out_answer_r;

  // stack pointer offsets and operands
  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign sp_m3   = sp_r - SPW'(3);
  assign earlier = ram_rdata;
  assign later   = top_r;
  assign prod    = earlier * later;
  assign quot    = neg_r ? (DW'(0) - quo_r) : quo_r;
  assign sp_ext  = {{rpn_pkg::DEPTH_W{1'b0}}, sp_r};

  // restoring divider step: shift in next numerator bit, try subtract
  assign trial = {rem_r, quo_r[DW-1]} - {1'b0, den_r};

  // sequencer next state and datapath
  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    halted_nxt     = halted_r;
    top_nxt        = top_r;
    cmd_nxt        = cmd_r;
    status_nxt     = status_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    den_nxt        = den_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_answer_nxt = out_answer_r;
    ram_we         = 1'b0;
    ram_waddr      = sp_m2[AW-1:0];
    ram_wdata      = quot;
    ram_raddr      = sp_m2[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt    = in_ch.cmd;
          status_nxt = rpn_pkg::ST_OK;
          state_nxt  = S_FINISH;
          if (halted_r) begin
            status_nxt = rpn_pkg::ST_HALT;
          end else if (in_ch.cmd == rpn_pkg::CMD_PUSH) begin
            if (sp_r == SPW'(STACK_DEPTH)) begin
              status_nxt = rpn_pkg::ST_FULL;
              halted_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = sp_r[AW-1:0];
              ram_wdata = in_ch.value;
              top_nxt   = in_ch.value;
              sp_nxt    = sp_r + SPW'(1);
            end
          end else if (sp_r < SPW'(2)) begin
            status_nxt = rpn_pkg::ST_FEW;
            halted_nxt = 1'b1;
          end else begin
            // fetch the entry under the cached top
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        state_nxt = S_FINISH;
        case (cmd_r)
          rpn_pkg::CMD_ADD: begin
            ram_we    = 1'b1;
            ram_wdata = earlier + later;
            top_nxt   = earlier + later;
            sp_nxt    = sp_m1;
          end
          rpn_pkg::CMD_SUB: begin
            ram_we    = 1'b1;
            ram_wdata = earlier - later;
            top_nxt   = earlier - later;
            sp_nxt    = sp_m1;
          end
          rpn_pkg::CMD_DIV: begin
            if (later == DW'(0)) begin
              status_nxt = rpn_pkg::ST_DIVZ;
              halted_nxt = 1'b1;
              sp_nxt     = sp_m2;
              if (sp_m2 != SPW'(0)) begin
                ram_raddr = sp_m3[AW-1:0];
                state_nxt = S_RELOAD;
              end else begin
                top_nxt = DW'(0);
              end
            end else begin
              // load magnitudes into the divider
              quo_nxt   = earlier[DW-1] ? (DW'(0) - earlier) : earlier;
              den_nxt   = later[DW-1] ? (DW'(0) - later) : later;
              neg_nxt   = earlier[DW-1] ^ later[DW-1];
              rem_nxt   = DW'(0);
              cnt_nxt   = CW'(0);
              state_nxt = S_DIVIDE;
            end
          end
          default: begin
            ram_we    = 1'b1;
            ram_wdata = prod;
            top_nxt   = prod;
            sp_nxt    = sp_m1;
          end
        endcase
      end

      S_DIVIDE: begin
        if (!trial[DW]) begin
          rem_nxt = trial[DW-1:0];
        end else begin
          rem_nxt = {rem_r[DW-2:0], quo_r[DW-1]};
        end
        quo_nxt = {quo_r[DW-2:0], !trial[DW]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(rpn_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DIV_DONE;
        end
      end

      S_DIV_DONE: begin
        ram_we    = 1'b1;
        ram_wdata = quot;
        top_nxt   = quot;
        sp_nxt    = sp_m1;
        state_nxt = S_FINISH;
      end

      S_RELOAD: begin
        top_nxt   = ram_rdata;
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        // hand the beat over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_top_nxt    = (sp_r == SPW'(0)) ? DW'(0) : top_r;
          out_depth_nxt  = sp_ext[rpn_pkg::DEPTH_W-1:0];
          out_answer_nxt = (status_r == rpn_pkg::ST_OK) && (sp_r == SPW'(1));
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    cmd_r        <= cmd_nxt;
    status_r     <= status_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    den_r        <= den_nxt;
    neg_r        <= neg_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_answer_r <= out_answer_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/rpn_chk.sv =====
// port-level checker for the rpn calculator, bound to the top level
`default_nettype none

module rpn_chk (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [rpn_pkg::STATUS_W-1:0]        out_status,
  input wire [rpn_pkg::DATA_W-1:0]          out_top_value,
  input wire [rpn_pkg::DEPTH_W-1:0]         out_depth,
  input wire                                out_answer_ready
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_top_value)
      && $stable(out_depth) && $stable(out_answer_ready))
    else $error("result payload changed while stalled");

  // answer flag only with ok status and a single entry
  a_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_answer_ready |->
      out_status == rpn_pkg::ST_OK && out_depth == rpn_pkg::DEPTH_W'(1))
    else $error("answer flag without single clean entry");

  // empty stack shows zero on top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth == '0 |-> out_top_value == '0)
    else $error("nonzero top on empty stack");

  // one token at a time: busy right after a token is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("token accepted while previous one in flight");

endmodule

bind rpn_stack_calculator_unit rpn_chk u_rpn_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_top_value    (out_ch.top_value),
  .out_depth        (out_ch.depth),
  .out_answer_ready (out_ch.answer_ready)
);

`default_nettype wire
